@@ rtl/core/crgr_pkg.sv @@
// shared types and constants for the clipped rectangle and glyph raster engine
`timescale 1ns / 1ps

package crgr_pkg;

  // default texture geometry
  localparam int TEX_WIDTH_DEF  = 512;
  localparam int TEX_HEIGHT_DEF = 256;

  // coordinate field width and widened clip arithmetic width
  localparam int COORD_W = 13;
  localparam int CLIP_W  = 15;

  // glyph box sizes
  localparam int GLYPH_NATIVE = 8;
  localparam int GLYPH_DOUBLE = 16;

  typedef enum logic [1:0] {
    ACT_FILL   = 2'd0,
    ACT_NATIVE = 2'd1,
    ACT_DOUBLE = 2'd2,
    ACT_READ   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CLIP,
    S_BASE,
    S_DRAW,
    S_READ,
    S_RWAIT,
    S_DONE
  } state_t;

endpackage

@@ rtl/core/crgr_tex_ram.sv @@
// single-port texture ram with registered read data
`timescale 1ns / 1ps

module crgr_tex_ram #(
  parameter int DEPTH = crgr_pkg::TEX_WIDTH_DEF * crgr_pkg::TEX_HEIGHT_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata
);

  import crgr_pkg::*;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/clipped_rect_and_glyph_raster.sv @@
// top level of the clipped rectangle fill and 8x8 glyph raster engine
`timescale 1ns / 1ps

// usage
// - in_ channel carries one command per beat: in_tuser is the action (fill,
//   native glyph, double glyph, read), in_tdata the coordinates, extents,
//   color index and glyph rows
// - out_ channel returns one beat per command: read data in out_tdata and
//   in out_tuser a flag that marks a read; drawing commands return zero
// - each command is clipped to the texture, then the clipped box is walked
//   one pixel per cycle through the single ram port
// - the clipped box area is at most w*h pixels for a fill, up to 64 for a
//   native glyph and up to 256 for a double glyph; a box clipped away
//   entirely is not walked
// - the single ram port does at most one write or one read each cycle
// - after reset a clearing pass writes zero to every texel, one per cycle,
//   TEX_WIDTH*TEX_HEIGHT texels (131072 by default); in_tready is low
// - results sit in an output register: the next command is accepted and
//   drawn while a result waits, and its own result holds until the
//   receiver takes the earlier one

module clipped_rect_and_glyph_raster #(
  parameter int TEX_WIDTH  = crgr_pkg::TEX_WIDTH_DEF,
  parameter int TEX_HEIGHT = crgr_pkg::TEX_HEIGHT_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [12:0] pos_x, [25:13] pos_y, [38:26] rect_width, [51:39] rect_height,
  // [59:52] color_index, [123:60] glyph_bits, [127:124] zero
  input  logic [127:0] in_tdata,
  // [1:0] action
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [7:0] read_color
  output logic [7:0]   out_tdata,
  // [0] was_read
  output logic         out_tuser
);

  import crgr_pkg::*;

  localparam int DEPTH = TEX_WIDTH * TEX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int CXW   = $clog2(TEX_WIDTH);
  localparam int CYW   = $clog2(TEX_HEIGHT);
  localparam logic signed [CLIP_W-1:0] WS = CLIP_W'(TEX_WIDTH);
  localparam logic signed [CLIP_W-1:0] HS = CLIP_W'(TEX_HEIGHT);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
  localparam logic [AW-1:0] ROW_STEP  = AW'(TEX_WIDTH);

  state_t state_r, state_nxt;

  // command registers
  action_t                    act_r, act_nxt;
  logic signed [COORD_W-1:0]  x_r, x_nxt;
  logic signed [COORD_W-1:0]  y_r, y_nxt;
  logic signed [COORD_W-1:0]  w_r, w_nxt;
  logic signed [COORD_W-1:0]  h_r, h_nxt;
  logic [7:0]                 color_r, color_nxt;
  logic [63:0]                glyph_r, glyph_nxt;

  // clipped box and walk counters
  logic [CXW-1:0] x0_r, x0_nxt, xl_r, xl_nxt, cx_r, cx_nxt;
  logic [CYW-1:0] y0_r, y0_nxt, yl_r, yl_nxt, cy_r, cy_nxt;
  logic [AW-1:0]  row_base_r, row_base_nxt;
  logic [AW-1:0]  clr_addr_r, clr_addr_nxt;

  // result and output register
  logic [7:0] res_color_r, res_color_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_color_r, out_color_nxt;
  logic       out_read_r, out_read_nxt;

  // ram port
  logic          mem_we;
  logic [AW-1:0] mem_addr;
  logic [7:0]    mem_wdata;
  logic [7:0]    mem_rdata;

  // clip arithmetic
  logic signed [CLIP_W-1:0] xs, ys, ex, ey, sx, sy, x1c, y1c, x0s, y0s;
  logic                     box_empty;

  // glyph mask lookup
  logic signed [CLIP_W-1:0] dx, dy;
  logic [2:0]               gx, gy;
  logic                     pix_on;
  logic                     out_free;

  crgr_tex_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // clip box: start clamps at zero, end clamps at the texture edge
  always_comb begin
    xs = $signed({{(CLIP_W-COORD_W){x_r[COORD_W-1]}}, x_r});
    ys = $signed({{(CLIP_W-COORD_W){y_r[COORD_W-1]}}, y_r});
    case (act_r)
      ACT_FILL: begin
        ex = $signed({{(CLIP_W-COORD_W){w_r[COORD_W-1]}}, w_r});
        ey = $signed({{(CLIP_W-COORD_W){h_r[COORD_W-1]}}, h_r});
      end
      ACT_NATIVE: begin
        ex = CLIP_W'(GLYPH_NATIVE);
        ey = CLIP_W'(GLYPH_NATIVE);
      end
      ACT_DOUBLE: begin
        ex = CLIP_W'(GLYPH_DOUBLE);
        ey = CLIP_W'(GLYPH_DOUBLE);
      end
      default: begin
        // a read is a one-pixel box, empty when out of range
        ex = CLIP_W'(1);
        ey = CLIP_W'(1);
      end
    endcase
    sx  = xs + ex;
    sy  = ys + ey;
    x1c = (sx > WS) ? WS : sx;
    y1c = (sy > HS) ? HS : sy;
    x0s = xs[CLIP_W-1] ? '0 : xs;
    y0s = ys[CLIP_W-1] ? '0 : ys;
    box_empty = (x1c <= x0s) || (y1c <= y0s);
  end

  // glyph bit under the current pixel, msb of each row leftmost
  always_comb begin
    dx = $signed({{(CLIP_W-CXW){1'b0}}, cx_r}) - xs;
    dy = $signed({{(CLIP_W-CYW){1'b0}}, cy_r}) - ys;
    if (act_r == ACT_DOUBLE) begin
      gx = dx[3:1];
      gy = dy[3:1];
    end else begin
      gx = dx[2:0];
      gy = dy[2:0];
    end
    pix_on = (act_r == ACT_FILL) || glyph_r[6'd63 - {gy, gx}];
  end

  assign out_free = !out_valid_r || out_tready;

  // next state, datapath and ram control
  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    color_nxt     = color_r;
    glyph_nxt     = glyph_r;
    x0_nxt        = x0_r;
    xl_nxt        = xl_r;
    y0_nxt        = y0_r;
    yl_nxt        = yl_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    row_base_nxt  = row_base_r;
    clr_addr_nxt  = clr_addr_r;
    res_color_nxt = res_color_r;
    out_valid_nxt = out_valid_r;
    out_color_nxt = out_color_r;
    out_read_nxt  = out_read_r;
    mem_we        = 1'b0;
    mem_addr      = row_base_r + AW'(cx_r);
    mem_wdata     = color_r;
    in_tready     = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_CLEAR: begin
        mem_we       = 1'b1;
        mem_addr     = clr_addr_r;
        mem_wdata    = '0;
        clr_addr_nxt = clr_addr_r + AW'(1);
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          act_nxt       = action_t'(in_tuser);
          x_nxt         = $signed(in_tdata[12:0]);
          y_nxt         = $signed(in_tdata[25:13]);
          w_nxt         = $signed(in_tdata[38:26]);
          h_nxt         = $signed(in_tdata[51:39]);
          color_nxt     = in_tdata[59:52];
          glyph_nxt     = in_tdata[123:60];
          res_color_nxt = '0;
          state_nxt     = S_CLIP;
        end
      end
      S_CLIP: begin
        x0_nxt = CXW'(x0s);
        xl_nxt = CXW'(x1c - CLIP_W'(1));
        y0_nxt = CYW'(y0s);
        yl_nxt = CYW'(y1c - CLIP_W'(1));
        state_nxt = box_empty ? S_DONE : S_BASE;
      end
      S_BASE: begin
        row_base_nxt = AW'(y0_r * TEX_WIDTH);
        cx_nxt       = x0_r;
        cy_nxt       = y0_r;
        state_nxt    = (act_r == ACT_READ) ? S_READ : S_DRAW;
      end
      S_DRAW: begin
        mem_we = pix_on;
        if (cx_r == xl_r) begin
          cx_nxt       = x0_r;
          cy_nxt       = cy_r + CYW'(1);
          row_base_nxt = row_base_r + ROW_STEP;
          if (cy_r == yl_r) begin
            state_nxt = S_DONE;
          end
        end else begin
          cx_nxt = cx_r + CXW'(1);
        end
      end
      S_READ: begin
        // address presented, data registered next cycle
        state_nxt = S_RWAIT;
      end
      S_RWAIT: begin
        res_color_nxt = mem_rdata;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_color_nxt = res_color_r;
          out_read_nxt  = (act_r == ACT_READ);
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    w_r         <= w_nxt;
    h_r         <= h_nxt;
    color_r     <= color_nxt;
    glyph_r     <= glyph_nxt;
    x0_r        <= x0_nxt;
    xl_r        <= xl_nxt;
    y0_r        <= y0_nxt;
    yl_r        <= yl_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    row_base_r  <= row_base_nxt;
    res_color_r <= res_color_nxt;
    out_color_r <= out_color_nxt;
    out_read_r  <= out_read_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_color_r;
  assign out_tuser  = out_read_r;

endmodule
